### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master controller package
// Shared types, opcodes, register codes and the divider width and reset value.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DivW = 12;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_STATUS = 2'd1;
  localparam logic [1:0] REG_DATA   = 2'd2;

  localparam logic [DivW-1:0] DIV_RESET = 12'd3840;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_HOLD, PH_LOW, PH_HIGH, PH_STOP, PH_STOP2, PH_RESTART
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       scl_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       scl_low;
    logic       sda_low;
    logic       interrupt;
  } rsp_t;

endpackage

### sv/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master core
// Holds the register and bit engine state and handles one request per cycle while step is high.
// ----------------------------------------------------------------------------
module i2cm_core import i2cm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  req_t            req,
  input  logic            cfg_we,
  input  logic [DivW-1:0] cfg_div,
  output rsp_t            rsp
);

  logic [DivW-1:0] div_r, div_nxt;
  logic en_r, en_nxt, ien_r, ien_nxt, ms_r, ms_nxt, tx_r, tx_nxt, txak_r, txak_nxt;
  logic xc_r, xc_nxt, bb_r, bb_nxt, al_r, al_nxt, if_r, if_nxt, rn_r, rn_nxt;
  logic [7:0] sh_r, sh_nxt, rx_r, rx_nxt;
  logic [3:0] bi_r, bi_nxt;
  logic [DivW-1:0] hc_r, hc_nxt;
  phase_t ph_r, ph_nxt;
  logic ps_r, ps_nxt, pd_r, pd_nxt, sc_r, sc_nxt, sd_r, sd_nxt;

  logic [DivW-2:0] half;
  logic [DivW-1:0] hlim;
  logic            hdone;
  logic [DivW-1:0] hc_inc;
  logic [7:0]      rd;
  logic            ms_b, in_byte, dacc;

  assign half   = div_r[DivW-1:1];
  assign hlim   = (half == '0) ? DivW'(1) : {1'b0, half};
  assign hc_inc = hc_r + DivW'(1);
  assign hdone  = (hc_inc >= hlim);

  always_comb begin
    div_nxt = cfg_we ? cfg_div : div_r;
    en_nxt = en_r; ien_nxt = ien_r; ms_nxt = ms_r; tx_nxt = tx_r; txak_nxt = txak_r;
    xc_nxt = xc_r; bb_nxt = bb_r; al_nxt = al_r; if_nxt = if_r; rn_nxt = rn_r;
    sh_nxt = sh_r; rx_nxt = rx_r; bi_nxt = bi_r; hc_nxt = hc_r; ph_nxt = ph_r;
    sc_nxt = sc_r; sd_nxt = sd_r;
    ps_nxt = ps_r; pd_nxt = pd_r;
    rd = 8'h00; ms_b = 1'b0; in_byte = 1'b0; dacc = 1'b0;
    if (step) begin
      if (en_r && ps_r && req.scl_in) begin
        if (pd_r && !req.sda_in) begin
          bb_nxt = 1'b1;
        end else if (!pd_r && req.sda_in) begin
          bb_nxt = 1'b0;
        end
      end
      ps_nxt = req.scl_in;
      pd_nxt = req.sda_in;
      in_byte = (ph_r == PH_LOW) || (ph_r == PH_HIGH);
      case (req.opcode)
        OP_TICK: begin
          case (ph_r)
            PH_START, PH_LOW, PH_STOP: begin
              hc_nxt = hdone ? '0 : hc_inc;
              if (hdone) begin
                if (ph_r == PH_START) begin
                  sc_nxt = 1'b1;
                  ph_nxt = PH_HOLD;
                  if (!xc_r) begin
                    xc_nxt = 1'b0; bi_nxt = '0; ph_nxt = PH_LOW;
                    sd_nxt = tx_r ? ~sh_r[7] : 1'b0;
                  end
                end else if (ph_r == PH_LOW) begin
                  sc_nxt = 1'b0; ph_nxt = PH_HIGH;
                end else begin
                  sc_nxt = 1'b0; ph_nxt = PH_STOP2;
                end
              end
            end
            PH_RESTART: begin
              if (bi_r == 4'd0) begin
                hc_nxt = hdone ? '0 : hc_inc;
                if (hdone) begin
                  sc_nxt = 1'b0; bi_nxt = 4'd1;
                end
              end else if (req.scl_in) begin
                hc_nxt = hdone ? '0 : hc_inc;
                if (hdone) begin
                  sd_nxt = 1'b1; bi_nxt = '0; ph_nxt = PH_START;
                end
              end
            end
            PH_STOP2: begin
              if (req.scl_in) begin
                hc_nxt = hdone ? '0 : hc_inc;
                if (hdone) begin
                  sd_nxt = 1'b0; ph_nxt = PH_IDLE;
                end
              end
            end
            PH_HIGH: begin
              if (req.scl_in) begin
                hc_nxt = hdone ? '0 : hc_inc;
                if (hdone) begin
                  sc_nxt = 1'b1;
                  if (!bi_r[3]) begin
                    if (tx_r && !sd_r && !req.sda_in) begin
                      al_nxt = 1'b1; if_nxt = 1'b1; xc_nxt = 1'b1; ms_nxt = 1'b0;
                      sc_nxt = 1'b0; sd_nxt = 1'b0; bi_nxt = '0; ph_nxt = PH_IDLE;
                    end else begin
                      sh_nxt = {sh_r[6:0], req.sda_in};
                      bi_nxt = bi_r + 4'd1;
                      ph_nxt = PH_LOW;
                      if (bi_r == 4'd7) begin
                        sd_nxt = tx_r ? 1'b0 : ~txak_r;
                      end else begin
                        sd_nxt = tx_r ? ~sh_r[6] : 1'b0;
                      end
                    end
                  end else begin
                    if (tx_r) begin
                      rn_nxt = req.sda_in;
                    end else begin
                      rx_nxt = sh_r;
                    end
                    sd_nxt = 1'b0; bi_nxt = '0; xc_nxt = 1'b1; if_nxt = 1'b1;
                    ph_nxt = PH_HOLD;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_WRITE: begin
          case (req.reg_select)
            REG_CTRL: begin
              ms_b = req.write_data[5];
              ien_nxt = req.write_data[6];
              tx_nxt = req.write_data[4];
              txak_nxt = req.write_data[3];
              if (!req.write_data[7]) begin
                en_nxt = 1'b0; ms_nxt = 1'b0; xc_nxt = 1'b1; bb_nxt = 1'b0;
                al_nxt = 1'b0; if_nxt = 1'b0; rn_nxt = 1'b0; bi_nxt = '0;
                hc_nxt = '0; ph_nxt = PH_IDLE; sc_nxt = 1'b0; sd_nxt = 1'b0;
              end else begin
                en_nxt = 1'b1;
                if (ms_b && !ms_r) begin
                  if (ph_r == PH_IDLE) begin
                    if (bb_nxt) begin
                      al_nxt = 1'b1; if_nxt = 1'b1;
                    end else begin
                      ms_nxt = 1'b1; ph_nxt = PH_START; sd_nxt = 1'b1;
                      sc_nxt = 1'b0; hc_nxt = '0; bi_nxt = '0;
                    end
                  end
                end else if (!ms_b && ms_r) begin
                  ms_nxt = 1'b0; ph_nxt = PH_STOP; sc_nxt = 1'b1; sd_nxt = 1'b1;
                  hc_nxt = '0; bi_nxt = '0;
                end else if (ms_b && req.write_data[2] && ph_r == PH_HOLD) begin
                  ph_nxt = PH_RESTART; bi_nxt = '0; sc_nxt = 1'b1; sd_nxt = 1'b0;
                  hc_nxt = '0;
                end
              end
            end
            REG_STATUS: begin
              al_nxt = al_r & req.write_data[4];
              if_nxt = if_r & req.write_data[1];
            end
            REG_DATA: begin
              if (!in_byte) begin
                sh_nxt = req.write_data;
                dacc = ms_r && tx_r;
              end
            end
            default: begin
            end
          endcase
        end
        OP_READ: begin
          case (req.reg_select)
            REG_CTRL: rd = {en_r, ien_r, ms_r, tx_r, txak_r, 3'b000};
            REG_STATUS: rd = {xc_r, 1'b0, bb_nxt, al_r, 2'b00, if_r, rn_r};
            REG_DATA: begin
              rd = rx_r;
              dacc = ms_r && !tx_r;
            end
            default: rd = 8'h00;
          endcase
        end
        default: begin
        end
      endcase
      if (dacc) begin
        if (ph_r == PH_HOLD) begin
          xc_nxt = 1'b0; bi_nxt = '0; hc_nxt = '0; ph_nxt = PH_LOW; sc_nxt = 1'b1;
          sd_nxt = tx_r ? ~sh_nxt[7] : 1'b0;
        end else if (ph_r == PH_START || ph_r == PH_RESTART) begin
          xc_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIV_RESET;
      en_r <= 1'b0; ien_r <= 1'b0; ms_r <= 1'b0; tx_r <= 1'b0; txak_r <= 1'b0;
      xc_r <= 1'b1; bb_r <= 1'b0; al_r <= 1'b0; if_r <= 1'b0; rn_r <= 1'b0;
      sh_r <= '0; rx_r <= '0; bi_r <= '0; hc_r <= '0; ph_r <= PH_IDLE;
      ps_r <= 1'b1; pd_r <= 1'b1; sc_r <= 1'b0; sd_r <= 1'b0;
    end else begin
      div_r <= div_nxt;
      en_r <= en_nxt; ien_r <= ien_nxt; ms_r <= ms_nxt; tx_r <= tx_nxt; txak_r <= txak_nxt;
      xc_r <= xc_nxt; bb_r <= bb_nxt; al_r <= al_nxt; if_r <= if_nxt; rn_r <= rn_nxt;
      sh_r <= sh_nxt; rx_r <= rx_nxt; bi_r <= bi_nxt; hc_r <= hc_nxt; ph_r <= ph_nxt;
      ps_r <= ps_nxt; pd_r <= pd_nxt; sc_r <= sc_nxt; sd_r <= sd_nxt;
    end
  end

  assign rsp.read_data = rd;
  assign rsp.scl_low   = sc_nxt;
  assign rsp.sda_low   = sd_nxt;
  assign rsp.interrupt = if_nxt & ien_nxt;

endmodule

### sv/i2c_master_controller.sv
// ----------------------------------------------------------------------------
// I2C master controller
// Byte-register I2C bus master with an SCL bit engine.
// ----------------------------------------------------------------------------
// Each request on the in_ channel is a clock tick, a register write or a
// register read, together with the sampled SCL and SDA levels. Every request
// gives exactly one response on the out_ channel with the read data, the two
// line drives and the interrupt output.
// The request is processed in the cycle it is accepted and its response sits
// in the output register from the next cycle, so a request can be accepted
// every cycle while the receiver takes the responses.
// When the receiver stalls, a new request is still taken if the output
// register is empty; otherwise in_ready is held low.
// The cfg_ channel writes the SCL divider; the user must write it only while idle, as the block does not enforce this.
// After reset the engine is idle, both lines are released, transfer-complete
// is set and the divider is 3840.
// ----------------------------------------------------------------------------
module i2c_master_controller import i2cm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_opcode,
  input  logic [1:0]      in_reg_select,
  input  logic [7:0]      in_write_data,
  input  logic            in_scl_in,
  input  logic            in_sda_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_read_data,
  output logic            out_scl_low,
  output logic            out_sda_low,
  output logic            out_interrupt,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [DivW-1:0] cfg_data
);

  req_t req;
  rsp_t rsp, rsp_r;
  logic vld_r, step;

  assign in_ready  = !vld_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign req = '{opcode: in_opcode, reg_select: in_reg_select, write_data: in_write_data,
                 scl_in: in_scl_in, sda_in: in_sda_in};

  i2cm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .req    (req),
    .cfg_we (cfg_valid),
    .cfg_div(cfg_data),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid     = vld_r;
  assign out_read_data = rsp_r.read_data;
  assign out_scl_low   = rsp_r.scl_low;
  assign out_sda_low   = rsp_r.sda_low;
  assign out_interrupt = rsp_r.interrupt;

endmodule
